[hdl/key_value_line_tokenizer_core_assert.svh]
// Assertion macros used by the tokenizer top level.
`ifndef KEY_VALUE_LINE_TOKENIZER_CORE_ASSERT_SVH
`define KEY_VALUE_LINE_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk while out of reset.
`define KVLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk while out of reset.
`define KVLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/kvlt_pkg.sv]
// Package: types, codes and character helpers of the line tokenizer.
`timescale 1ns / 1ps
package kvlt_pkg;

  localparam int MAX_BLANK_RUN_DEF = 16;
  localparam int LINE_BITS_DEF     = 16;

  localparam logic [7:0] CHAR_HASH       = 8'h23;
  localparam logic [7:0] CHAR_EQ         = 8'h3D;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NO_NAME   = 2'd0;
  localparam logic [1:0] ERR_NO_VALUE  = 2'd1;
  localparam logic [1:0] ERR_NO_EQ     = 2'd2;
  localparam logic [1:0] ERR_BLANK_OVF = 2'd3;

  typedef enum logic [2:0] {
    PH_START,
    PH_NAME,
    PH_AFTER_NAME,
    PH_AFTER_EQ,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPLAY,
    ST_TAIL
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic step;       // input transfer: run one parse step
    logic rep_emit;   // load next held blank into the output register
    logic tail_emit;  // load the pending value byte, last of item
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic replay_req; // current input item would replay held blanks
    logic rep_last;   // blank on the read port is the last one held
  } dp_stat_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0B, 8'h0C};
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
           (b == CHAR_UNDERSCORE);
  endfunction

endpackage

[hdl/key_value_line_tokenizer_core.sv]
// Top level of the name=value line tokenizer: controller plus datapath.
`timescale 1ns / 1ps
// Byte-serial tokenizer for name=value property lines. Each input transfer
// carries one document byte (or an end-of-text / new-document marker) and
// yields zero or one result, except a value byte that follows held inner
// blanks: it yields the n held blanks and then the byte itself, n+1 results.
// Timing: results come from a single output register, so the result of a
// plain item is visible the cycle after its input transfer. In a replay the
// first held blank shows later, as it passes the registered blank store read
// and then the output register. With the output side taking every cycle, the
// block accepts one byte per cycle outside a replay; an item that replays n
// held blanks takes the transfer, n reads from the two-port blank store and
// the final byte, with in_stall high until that byte is loaded. Backpressure
// on out_stall holds in_stall high while the output register is full and not
// being drained. The comment character is written with cfg_wr_en/cfg_wr_data
// and resets to '#'. The blank store needs no clearing pass after reset; only
// entries written since the last replay are ever read. An error result ends
// parsing until an item with in_new_document set arrives; tokens already
// delivered for that document are to be discarded by the consumer.
module key_value_line_tokenizer_core #(
  parameter int MAX_BLANK_RUN = kvlt_pkg::MAX_BLANK_RUN_DEF,
  parameter int LINE_BITS     = kvlt_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  input  logic        in_new_document,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_token_kind,
  output logic [7:0]  out_token_byte,
  output logic [15:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_item
);
  import kvlt_pkg::*;

  `include "key_value_line_tokenizer_core_assert.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // terms used by the checks at the end
  logic replay_start;
  logic replay_busy;
  logic out_nonlast;
  logic out_byte_tok;
  logic out_aux_zero;

  // sequencing: when to take an input transfer, when to replay blanks
  kvlt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .stat    (stat),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  // parse state, blank store, line count and output register
  kvlt_dpath #(
    .MAX_BLANK_RUN(MAX_BLANK_RUN),
    .LINE_BITS    (LINE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .in_new_document (in_new_document),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_token_kind  (out_token_kind),
    .out_token_byte  (out_token_byte),
    .out_line_number (out_line_number),
    .out_error_code  (out_error_code),
    .out_last_of_item(out_last_of_item)
  );

  assign replay_start = cmd.step && stat.replay_req;
  assign replay_busy  = cmd.rep_emit || cmd.tail_emit;
  assign out_nonlast  = out_valid && !out_last_of_item;
  assign out_byte_tok = out_valid &&
                        ((out_token_kind == KIND_NAME) || (out_token_kind == KIND_VALUE));
  assign out_aux_zero = (out_line_number == 16'd0) && (out_error_code == 2'd0);

  // Replay must hold off the input side until the pending byte is out.
  `KVLT_ASSERT_NXT(a_replay_blocks_input, replay_start, in_stall, "input open after replay")
  `KVLT_ASSERT_IMP(a_replay_blocks_input_busy, replay_busy, in_stall, "input open in replay")
  // Only replayed blanks can be non-final results, and they are value bytes.
  `KVLT_ASSERT_IMP(a_non_last_is_value, out_nonlast, out_token_kind == KIND_VALUE, "bad non-final")
  // Byte tokens carry no line number and no error code.
  `KVLT_ASSERT_IMP(a_byte_token_clean, out_byte_tok, out_aux_zero, "byte token fields set")

endmodule

[hdl/kvlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kvlt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/kvlt_ctrl.sv]
// Controller: input acceptance and held-blank replay sequencing.
`timescale 1ns / 1ps
module kvlt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  kvlt_pkg::dp_stat_t stat,
  output kvlt_pkg::dp_cmd_t  cmd,
  output logic               in_stall
);
  import kvlt_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_RUN: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.replay_req) begin
            state_nxt = ST_REPLAY;
          end
        end
      end
      ST_REPLAY: begin
        if (stat.out_free) begin
          cmd.rep_emit = 1'b1;
          if (stat.rep_last) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (stat.out_free) begin
          cmd.tail_emit = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

[hdl/kvlt_dpath.sv]
// Datapath: parse state, blank store, line counter and output register.
`timescale 1ns / 1ps
module kvlt_dpath #(
  parameter int MAX_BLANK_RUN = kvlt_pkg::MAX_BLANK_RUN_DEF,
  parameter int LINE_BITS     = kvlt_pkg::LINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic [7:0]         in_text_byte,
  input  logic               in_end_of_text,
  input  logic               in_new_document,
  input  kvlt_pkg::dp_cmd_t  cmd,
  output kvlt_pkg::dp_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_token_kind,
  output logic [7:0]         out_token_byte,
  output logic [15:0]        out_line_number,
  output logic [1:0]         out_error_code,
  output logic               out_last_of_item
);
  import kvlt_pkg::*;

  localparam int IDX_W = (MAX_BLANK_RUN > 1) ? $clog2(MAX_BLANK_RUN) : 1;
  localparam int CNT_W = $clog2(MAX_BLANK_RUN + 1);

  // parse state
  phase_t               ph_r, ph_nxt;
  logic                 cmt_r, cmt_nxt;
  logic                 stop_r, stop_nxt;
  logic                 hv_r, hv_nxt;
  logic [1:0]           hc_r, hc_nxt;
  logic [7:0]           hb_r, hb_nxt;
  logic [LINE_BITS-1:0] nl_r, nl_nxt;
  logic [CNT_W-1:0]     bc_r, bc_nxt;
  logic [IDX_W-1:0]     rp_r, rp_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [7:0]           cchar_r;

  // output register
  logic                 ov_r, ov_nxt;
  logic [1:0]           ok_r, ok_nxt;
  logic [7:0]           ob_r, ob_nxt;
  logic [15:0]          ol_r, ol_nxt;
  logic [1:0]           oc_r, oc_nxt;
  logic                 olast_r, olast_nxt;

  // effective state after a new-document clear
  phase_t               ph_e;
  logic                 cmt_e, stop_e, hv_e;
  logic [1:0]           hc_e;
  logic [7:0]           hb_e;
  logic [LINE_BITS-1:0] nl_e;
  logic [CNT_W-1:0]     bc_e;

  // outcome of one parse step
  phase_t               s_ph;
  logic                 s_cmt, s_stop, s_hv;
  logic [1:0]           s_hc;
  logic [7:0]           s_hb;
  logic [LINE_BITS-1:0] s_nl;
  logic [CNT_W-1:0]     s_bc;
  logic                 s_emit, s_replay, s_wr;
  logic [1:0]           s_kind, s_code;
  logic [7:0]           s_byte;
  logic                 line_end;
  logic [LINE_BITS+15:0] nl_ext;

  logic [7:0]           rd_data;
  logic                 out_free;
  logic                 rep_last;

  assign out_free = !ov_r || !out_stall;
  assign rep_last = (CNT_W'(rp_r) + CNT_W'(1)) == bc_r;
  assign nl_ext   = {16'd0, s_nl};

  always_comb begin
    stat            = '0;
    stat.out_free   = out_free;
    stat.replay_req = s_replay;
    stat.rep_last   = rep_last;
  end

  assign line_end = in_end_of_text || (in_text_byte == CHAR_LF) ||
                    (in_text_byte == CHAR_CR);

  always_comb begin
    ph_e   = in_new_document ? PH_START : ph_r;
    cmt_e  = in_new_document ? 1'b0 : cmt_r;
    stop_e = in_new_document ? 1'b0 : stop_r;
    hv_e   = in_new_document ? 1'b0 : hv_r;
    hc_e   = in_new_document ? 2'd0 : hc_r;
    hb_e   = in_new_document ? 8'd0 : hb_r;
    nl_e   = in_new_document ? '0 : nl_r;
    bc_e   = in_new_document ? '0 : bc_r;
  end

  always_comb begin
    s_ph     = ph_e;
    s_cmt    = cmt_e;
    s_stop   = stop_e;
    s_hv     = hv_e;
    s_hc     = hc_e;
    s_hb     = hb_e;
    s_nl     = nl_e;
    s_bc     = bc_e;
    s_emit   = 1'b0;
    s_replay = 1'b0;
    s_wr     = 1'b0;
    s_kind   = KIND_NAME;
    s_code   = ERR_NO_NAME;
    s_byte   = 8'd0;
    if (!stop_e) begin
      if (line_end) begin
        if (!in_end_of_text && (in_text_byte == CHAR_LF) && (nl_e != '1)) begin
          s_nl = nl_e + LINE_BITS'(1);
        end
        if (hv_e) begin
          s_emit = 1'b1;
          s_kind = KIND_ERROR;
          s_code = hc_e;
          s_byte = (hc_e == ERR_NO_EQ) ? hb_e : 8'd0;
          s_stop = 1'b1;
        end else if ((ph_e == PH_NAME) || (ph_e == PH_AFTER_NAME)) begin
          s_emit = 1'b1;
          s_kind = KIND_ERROR;
          s_code = ERR_NO_VALUE;
          s_stop = 1'b1;
        end else if ((ph_e == PH_AFTER_EQ) || (ph_e == PH_VALUE)) begin
          s_emit = 1'b1;
          s_kind = KIND_DONE;
        end
        s_ph  = PH_START;
        s_cmt = 1'b0;
        s_bc  = '0;
        s_hv  = 1'b0;
      end else if (hv_e || cmt_e) begin
        // rest of the line is skipped
      end else if ((ph_e == PH_START) && is_blank(in_text_byte)) begin
        // leading blank dropped
      end else if (in_text_byte == cchar_r) begin
        s_cmt = 1'b1;
      end else begin
        case (ph_e)
          PH_START: begin
            if (is_name_char(in_text_byte)) begin
              s_emit = 1'b1;
              s_kind = KIND_NAME;
              s_byte = in_text_byte;
              s_ph   = PH_NAME;
            end else begin
              s_hv = 1'b1;
              s_hc = ERR_NO_NAME;
              s_hb = 8'd0;
              s_bc = '0;
            end
          end
          PH_NAME: begin
            if (is_name_char(in_text_byte)) begin
              s_emit = 1'b1;
              s_kind = KIND_NAME;
              s_byte = in_text_byte;
            end else if (is_blank(in_text_byte)) begin
              s_ph = PH_AFTER_NAME;
            end else if (in_text_byte == CHAR_EQ) begin
              s_ph = PH_AFTER_EQ;
            end else begin
              s_hv = 1'b1;
              s_hc = ERR_NO_EQ;
              s_hb = in_text_byte;
              s_bc = '0;
            end
          end
          PH_AFTER_NAME: begin
            if (in_text_byte == CHAR_EQ) begin
              s_ph = PH_AFTER_EQ;
            end else if (!is_blank(in_text_byte)) begin
              s_hv = 1'b1;
              s_hc = ERR_NO_EQ;
              s_hb = in_text_byte;
              s_bc = '0;
            end
          end
          PH_AFTER_EQ: begin
            if (!is_blank(in_text_byte)) begin
              s_emit = 1'b1;
              s_kind = KIND_VALUE;
              s_byte = in_text_byte;
              s_ph   = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (is_blank(in_text_byte)) begin
              if (bc_e < CNT_W'(MAX_BLANK_RUN)) begin
                s_wr = 1'b1;
                s_bc = bc_e + CNT_W'(1);
              end else begin
                s_hv = 1'b1;
                s_hc = ERR_BLANK_OVF;
                s_hb = 8'd0;
                s_bc = '0;
              end
            end else if (bc_e != '0) begin
              s_replay = 1'b1;  // held blanks go out first, byte after them
            end else begin
              s_emit = 1'b1;
              s_kind = KIND_VALUE;
              s_byte = in_text_byte;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    cmt_nxt   = cmt_r;
    stop_nxt  = stop_r;
    hv_nxt    = hv_r;
    hc_nxt    = hc_r;
    hb_nxt    = hb_r;
    nl_nxt    = nl_r;
    bc_nxt    = bc_r;
    rp_nxt    = rp_r;
    pend_nxt  = pend_r;
    ov_nxt    = ov_r && out_stall;
    ok_nxt    = ok_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    oc_nxt    = oc_r;
    olast_nxt = olast_r;
    if (cmd.step) begin
      ph_nxt   = s_ph;
      cmt_nxt  = s_cmt;
      stop_nxt = s_stop;
      hv_nxt   = s_hv;
      hc_nxt   = s_hc;
      hb_nxt   = s_hb;
      nl_nxt   = s_nl;
      bc_nxt   = s_bc;
      rp_nxt   = '0;
      if (s_replay) begin
        pend_nxt = in_text_byte;
      end
      if (s_emit) begin
        ov_nxt    = 1'b1;
        ok_nxt    = s_kind;
        ob_nxt    = s_byte;
        ol_nxt    = ((s_kind == KIND_DONE) || (s_kind == KIND_ERROR)) ?
                    nl_ext[15:0] : 16'd0;
        oc_nxt    = (s_kind == KIND_ERROR) ? s_code : 2'd0;
        olast_nxt = 1'b1;
      end
    end else if (cmd.rep_emit) begin
      ov_nxt    = 1'b1;
      ok_nxt    = KIND_VALUE;
      ob_nxt    = rd_data;
      ol_nxt    = 16'd0;
      oc_nxt    = 2'd0;
      olast_nxt = 1'b0;
      if (!rep_last) begin
        rp_nxt = rp_r + IDX_W'(1);
      end
    end else if (cmd.tail_emit) begin
      ov_nxt    = 1'b1;
      ok_nxt    = KIND_VALUE;
      ob_nxt    = pend_r;
      ol_nxt    = 16'd0;
      oc_nxt    = 2'd0;
      olast_nxt = 1'b1;
      bc_nxt    = '0;
      rp_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_START;
      cmt_r   <= 1'b0;
      stop_r  <= 1'b0;
      hv_r    <= 1'b0;
      hc_r    <= 2'd0;
      hb_r    <= 8'd0;
      nl_r    <= '0;
      bc_r    <= '0;
      rp_r    <= '0;
      ov_r    <= 1'b0;
      cchar_r <= CHAR_HASH;
    end else begin
      ph_r   <= ph_nxt;
      cmt_r  <= cmt_nxt;
      stop_r <= stop_nxt;
      hv_r   <= hv_nxt;
      hc_r   <= hc_nxt;
      hb_r   <= hb_nxt;
      nl_r   <= nl_nxt;
      bc_r   <= bc_nxt;
      rp_r   <= rp_nxt;
      ov_r   <= ov_nxt;
      if (cfg_wr_en) begin
        cchar_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    ok_r    <= ok_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
    oc_r    <= oc_nxt;
    olast_r <= olast_nxt;
  end

  // read port always fetches the entry rp_r will point at next cycle
  kvlt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BLANK_RUN),
    .ADDR_W(IDX_W)
  ) u_blank_ram (
    .clk    (clk),
    .wr_en  (cmd.step && s_wr),
    .wr_addr(bc_e[IDX_W-1:0]),
    .wr_data(in_text_byte),
    .rd_addr(rp_nxt),
    .rd_data(rd_data)
  );

  assign out_valid        = ov_r;
  assign out_token_kind   = ok_r;
  assign out_token_byte   = ob_r;
  assign out_line_number  = ol_r;
  assign out_error_code   = oc_r;
  assign out_last_of_item = olast_r;

endmodule
